### hdl/swpf_pkg.sv
// servo write packet framer: shared types, codes and packet constants
// used by every module of the framer; depends on nothing

package swpf_pkg;

    typedef enum logic [1:0] {
        OP_GOAL_POS    = 2'd0,
        OP_JOINT_MODE  = 2'd1,
        OP_WHEEL_MODE  = 2'd2,
        OP_WHEEL_SPEED = 2'd3
    } t_op;

    localparam logic [1:0] LINK_TOP   = 2'd0;
    localparam logic [1:0] LINK_LEFT  = 2'd1;
    localparam logic [1:0] LINK_RIGHT = 2'd2;

    localparam logic [7:0] HDR_BYTE         = 8'hFF;
    localparam logic [7:0] INSTR_WRITE      = 8'h03;
    localparam logic [7:0] LEN_LONG         = 8'h07;
    localparam logic [7:0] LEN_SHORT        = 8'h06;
    localparam logic [7:0] ADDR_GOAL_POS    = 8'h1E;
    localparam logic [7:0] ADDR_MODE        = 8'h06;
    localparam logic [7:0] ADDR_WHEEL_SPEED = 8'h20;
    localparam logic [7:0] JOINT_PAR_2      = 8'hFF;
    localparam logic [7:0] JOINT_PAR_3      = 8'h03;
    localparam logic [10:0] DIR_BIT         = 11'h400;
    localparam logic signed [15:0] SPEED_LIMIT = 16'sd1023;
    localparam logic [7:0] NODE_ID_RESET    = 8'h01;

    // byte positions inside a packet
    localparam int unsigned BYTE_IDX_W = 4;
    localparam logic [BYTE_IDX_W-1:0] IDX_HDR0  = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] IDX_HDR1  = 4'd1;
    localparam logic [BYTE_IDX_W-1:0] IDX_NODE  = 4'd2;
    localparam logic [BYTE_IDX_W-1:0] IDX_LEN   = 4'd3;
    localparam logic [BYTE_IDX_W-1:0] IDX_INSTR = 4'd4;
    localparam logic [BYTE_IDX_W-1:0] IDX_ADDR  = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] IDX_PAR0  = 4'd6;
    localparam logic [BYTE_IDX_W-1:0] IDX_PAR1  = 4'd7;
    localparam logic [BYTE_IDX_W-1:0] IDX_PAR2  = 4'd8;
    localparam logic [BYTE_IDX_W-1:0] IDX_PAR3  = 4'd9;
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST_LONG  = 4'd10;
    localparam logic [BYTE_IDX_W-1:0] IDX_LAST_SHORT = 4'd9;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  target;
        logic [9:0]  position;
        logic [15:0] speed;
        logic [7:0]  acceleration;
    } t_cmd;

    typedef struct packed {
        logic [1:0] link;
        logic [7:0] data_byte;
        logic       last;
    } t_byte;

    typedef struct packed {
        logic [1:0]      link;
        logic [7:0]      node_id;
        logic [7:0]      len;
        logic [7:0]      addr;
        logic [3:0][7:0] par;
        logic            short_pkt;
        logic [7:0]      chk;
    } t_desc;

endpackage

### hdl/swpf_front.sv
// framer front end: classifies a command, builds the packet descriptor
// and checksum, pushes it into the queue; depends on swpf_pkg

module swpf_front (
    input  logic           i_cmd_valid,
    input  swpf_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_node_id,
    input  logic           i_q_full,
    output logic           o_push,
    output swpf_pkg::t_desc o_desc
);

    logic              emits;
    logic signed [15:0] spd_s;
    logic signed [15:0] spd_neg;
    logic [10:0]       wheel_word;
    logic [7:0]        sum;
    swpf_pkg::t_desc   desc;

    assign spd_s   = $signed(i_cmd.speed);
    assign spd_neg = -spd_s;

    // clamp to the speed limit, then sign-magnitude with direction bit
    always_comb begin
        if (spd_s > swpf_pkg::SPEED_LIMIT) begin
            wheel_word = 11'(swpf_pkg::SPEED_LIMIT);
        end else if (spd_s < -swpf_pkg::SPEED_LIMIT) begin
            wheel_word = swpf_pkg::DIR_BIT | 11'(swpf_pkg::SPEED_LIMIT);
        end else if (spd_s[15]) begin
            wheel_word = swpf_pkg::DIR_BIT | {1'b0, spd_neg[9:0]};
        end else begin
            wheel_word = spd_s[10:0];
        end
    end

    always_comb begin
        desc           = '0;
        desc.node_id   = i_node_id;
        desc.link      = swpf_pkg::LINK_TOP;
        desc.len       = swpf_pkg::LEN_LONG;
        desc.addr      = swpf_pkg::ADDR_MODE;
        desc.short_pkt = 1'b0;
        emits          = 1'b0;
        unique case (swpf_pkg::t_op'(i_cmd.op))
            swpf_pkg::OP_GOAL_POS: begin
                emits       = (i_cmd.target == swpf_pkg::LINK_TOP);
                desc.addr   = swpf_pkg::ADDR_GOAL_POS;
                desc.par[0] = i_cmd.position[7:0];
                desc.par[1] = {6'd0, i_cmd.position[9:8]};
                desc.par[2] = i_cmd.speed[7:0];
                desc.par[3] = i_cmd.speed[15:8];
            end
            swpf_pkg::OP_JOINT_MODE: begin
                emits       = (i_cmd.target == swpf_pkg::LINK_TOP);
                desc.par[2] = swpf_pkg::JOINT_PAR_2;
                desc.par[3] = swpf_pkg::JOINT_PAR_3;
            end
            swpf_pkg::OP_WHEEL_MODE: begin
                emits     = (i_cmd.target == swpf_pkg::LINK_LEFT) ||
                            (i_cmd.target == swpf_pkg::LINK_RIGHT);
                desc.link = i_cmd.target;
            end
            swpf_pkg::OP_WHEEL_SPEED: begin
                emits          = (i_cmd.target == swpf_pkg::LINK_LEFT) ||
                                 (i_cmd.target == swpf_pkg::LINK_RIGHT);
                desc.link      = i_cmd.target;
                desc.len       = swpf_pkg::LEN_SHORT;
                desc.addr      = swpf_pkg::ADDR_WHEEL_SPEED;
                desc.short_pkt = 1'b1;
                desc.par[0]    = wheel_word[7:0];
                desc.par[1]    = {5'd0, wheel_word[10:8]};
                desc.par[2]    = i_cmd.acceleration;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
    end

    // unused fourth parameter is zero on short packets, so it adds nothing
    assign sum = desc.node_id + desc.len + swpf_pkg::INSTR_WRITE + desc.addr
               + desc.par[0] + desc.par[1] + desc.par[2] + desc.par[3];

    always_comb begin
        o_desc     = desc;
        o_desc.chk = ~sum;
    end

    assign o_push = i_cmd_valid && !i_q_full && emits;

endmodule

### hdl/swpf_queue.sv
// short descriptor queue between framer front and back
// depends on swpf_pkg

module swpf_queue #(
    parameter int unsigned DEPTH = swpf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swpf_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output swpf_pkg::t_desc o_desc
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    swpf_pkg::t_desc r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

### hdl/swpf_back.sv
// framer back end: walks the head descriptor into the output register one byte
// a cycle while the byte channel is not stalled; depends on swpf_pkg

module swpf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  swpf_pkg::t_desc i_desc,
    output logic            o_pop,
    output logic            o_byte_valid,
    output swpf_pkg::t_byte o_byte,
    input  logic            i_byte_stall
);

    logic [swpf_pkg::BYTE_IDX_W-1:0] r_idx, n_idx;
    logic [swpf_pkg::BYTE_IDX_W-1:0] last_idx;
    logic                            r_valid;
    swpf_pkg::t_byte                 r_byte;
    logic                            load;
    logic                            emit;
    logic                            is_last;
    logic [7:0]                      body;

    assign load     = !r_valid || !i_byte_stall;
    assign emit     = i_q_valid && load;
    assign last_idx = i_desc.short_pkt ? swpf_pkg::IDX_LAST_SHORT
                                       : swpf_pkg::IDX_LAST_LONG;
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = emit && is_last;

    always_comb begin
        unique case (r_idx)
            swpf_pkg::IDX_HDR0:  body = swpf_pkg::HDR_BYTE;
            swpf_pkg::IDX_HDR1:  body = swpf_pkg::HDR_BYTE;
            swpf_pkg::IDX_NODE:  body = i_desc.node_id;
            swpf_pkg::IDX_LEN:   body = i_desc.len;
            swpf_pkg::IDX_INSTR: body = swpf_pkg::INSTR_WRITE;
            swpf_pkg::IDX_ADDR:  body = i_desc.addr;
            swpf_pkg::IDX_PAR0:  body = i_desc.par[0];
            swpf_pkg::IDX_PAR1:  body = i_desc.par[1];
            swpf_pkg::IDX_PAR2:  body = i_desc.par[2];
            swpf_pkg::IDX_PAR3:  body = i_desc.par[3];
            default:             body = i_desc.chk;
        endcase
    end

    always_comb begin
        if (o_pop) begin
            n_idx = '0;
        end else if (emit) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte.link      <= i_desc.link;
            r_byte.data_byte <= is_last ? i_desc.chk : body;
            r_byte.last      <= is_last;
        end
    end

    assign o_byte_valid = r_valid;
    assign o_byte       = r_byte;

    a_mid_packet_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> i_q_valid)
        else $error("byte index advanced with no descriptor at head");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= swpf_pkg::IDX_LAST_LONG)
        else $error("byte index past end of packet");

endmodule

### hdl/servo_write_packet_framer.sv
// servo write packet framer, top level: config register, front, queue, back
// depends on swpf_pkg, swpf_front, swpf_queue, swpf_back
//
// usage:
//   command channel (i_cmd_valid / o_cmd_stall / i_cmd): one command per
//   transfer. a valid command/link pairing becomes one write packet, any
//   other pairing is taken and dropped without output.
//   byte channel (o_byte_valid / i_byte_stall / o_byte): one packet byte per
//   transfer, tagged with its link; last is set on the checksum byte.
//   node_id is written over the apb port (paddr is not decoded); the user
//   must write it only while the block is idle; the block does not enforce it.
// when the back end is free, a taken command's first byte passes the queue and
//   then the output register. the byte serializer sends one byte per cycle
//   while the byte channel is not stalled; 11 bytes per long packet, 10 per wheel-speed.
// the front takes commands while the back drains, until the two-entry
//   descriptor queue is full; then o_cmd_stall rises.
// reset clears the queue, the serializer and the output valid, and sets
//   node_id to 1. a stall on the byte channel holds the output byte and
//   backs up into the queue, then the command channel.

module servo_write_packet_framer #(
    parameter int unsigned QUEUE_DEPTH = swpf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_stall,
    input  swpf_pkg::t_cmd  i_cmd,
    output logic            o_byte_valid,
    input  logic            i_byte_stall,
    output swpf_pkg::t_byte o_byte,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic            [7:0] r_node_id;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_valid;
    swpf_pkg::t_desc       push_desc;
    swpf_pkg::t_desc       head_desc;

    // single register, every offset in the window maps to it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= swpf_pkg::NODE_ID_RESET;
        end else if (psel && penable && pwrite && (paddr[1:0] == paddr)) begin
            r_node_id <= pwdata[7:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = {24'd0, r_node_id};
    assign o_cmd_stall = q_full;

    swpf_front u_front (
        .i_cmd_valid (i_cmd_valid),
        .i_cmd       (i_cmd),
        .i_node_id   (r_node_id),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    swpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    swpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_desc       (head_desc),
        .o_pop        (pop),
        .o_byte_valid (o_byte_valid),
        .o_byte       (o_byte),
        .i_byte_stall (i_byte_stall)
    );

endmodule
